>>> rtl/vstu_pkg.sv
// Shared types, codes and constants of the video scroll timing unit.
// No dependencies; used by the channel interfaces and the top level.
package vstu_pkg;

    // Request operations
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Register selects (low three bits of the CPU address)
    localparam logic [2:0] REG_CTRL     = 3'd0;
    localparam logic [2:0] REG_MASK     = 3'd1;
    localparam logic [2:0] REG_STATUS   = 3'd2;
    localparam logic [2:0] REG_OAM_ADDR = 3'd3;
    localparam logic [2:0] REG_OAM_DATA = 3'd4;
    localparam logic [2:0] REG_SCROLL   = 3'd5;
    localparam logic [2:0] REG_ADDR     = 3'd6;
    localparam logic [2:0] REG_DATA     = 3'd7;

    localparam logic [15:0] DMA_PAGE_ADDR = 16'h4014;

    // Memory request kinds
    localparam logic [2:0] KIND_NONE     = 3'd0;
    localparam logic [2:0] KIND_CPU_RD   = 3'd1;
    localparam logic [2:0] KIND_CPU_WR   = 3'd2;
    localparam logic [2:0] KIND_NT       = 3'd3;
    localparam logic [2:0] KIND_ATTR     = 3'd4;
    localparam logic [2:0] KIND_PAT_LO   = 3'd5;
    localparam logic [2:0] KIND_PAT_HI   = 3'd6;
    localparam logic [2:0] KIND_RESERVED = 3'd7;

    // Timing
    localparam logic [8:0] DOT_LAST       = 9'd340;
    localparam logic [8:0] LINE_LAST      = 9'd261;
    localparam logic [8:0] LINE_VBLANK    = 9'd241;
    localparam logic [8:0] LINE_VISIBLE   = 9'd240;
    localparam logic [8:0] DOT_FINE_Y     = 9'd256;
    localparam logic [8:0] DOT_COPY_H     = 9'd257;
    localparam logic [8:0] DOT_COPY_V_LO  = 9'd280;
    localparam logic [8:0] DOT_COPY_V_HI  = 9'd304;
    localparam logic [8:0] DOT_PREFETCH   = 9'd321;
    localparam logic [8:0] DOT_PREFETCH_A = 9'd328;
    localparam logic [8:0] DOT_PREFETCH_B = 9'd336;

    // Address composition
    localparam logic [13:0] NT_BASE    = 14'h2000;
    localparam logic [13:0] ATTR_BASE  = 14'h23C0;
    localparam logic [14:0] HORIZ_MASK = 15'h041F;
    localparam logic [14:0] VERT_MASK  = 15'h7BE0;
    localparam logic [4:0]  ROW_WRAP   = 5'd29;
    localparam logic [4:0]  ROW_LAST   = 5'd31;

    localparam int unsigned OAM_DEPTH = 256;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] reg_addr;
        logic [7:0]  write_data;
        logic [7:0]  fetch_data;
    } t_req;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [2:0]  mem_kind;
        logic [13:0] mem_addr;
        logic [7:0]  mem_wdata;
        logic        vblank_flag;
        logic        nmi_line;
        logic [8:0]  dot_now;
        logic [8:0]  line_now;
        logic [2:0]  fine_x_out;
    } t_rsp;

endpackage

>>> rtl/vstu_req_if.sv
// Request channel of the video scroll timing unit: valid, ready and payload.
// Depends on vstu_pkg for the payload type.
interface vstu_req_if;
    logic          valid;
    logic          ready;
    vstu_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/vstu_rsp_if.sv
// Response channel of the video scroll timing unit: valid, ready and payload.
// Depends on vstu_pkg for the payload type.
interface vstu_rsp_if;
    logic          valid;
    logic          ready;
    vstu_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/video_scroll_timing_unit_top.sv
// A response is registered and becomes valid in the cycle after its request is accepted.
// Throughput: one request per cycle; the single response register refills in the
// same cycle it is taken, so only a stalled response holds off the next request.
// OAM reads use the registered read port of the OAM (256 bytes by default) in that same cycle.
// Reset: synchronous, active low; clears counters, scroll and control state and
// the response valid; OAM contents are not cleared and read as garbage until written.
module video_scroll_timing_unit_top #(
    parameter int unsigned SPRITE_RAM_DEPTH = vstu_pkg::OAM_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vstu_req_if.sink   i_req,
    vstu_rsp_if.source o_rsp
);
    import vstu_pkg::*;

    localparam int unsigned OAM_AW = $clog2(SPRITE_RAM_DEPTH);

    // ---------------------------------------------------------------------
    // Architectural state
    // ---------------------------------------------------------------------
    logic [14:0] r_cur,  n_cur;       // current VRAM / scroll address
    logic [14:0] r_tmp,  n_tmp;       // temporary address
    logic [2:0]  r_fine_x, n_fine_x;
    logic        r_second_write, n_second_write;
    logic [4:0]  r_ctrl, n_ctrl;      // inc32, spr base, bg base, tall, nmi enable
    logic [7:0]  r_oam_addr, n_oam_addr;
    logic        r_vblank, n_vblank;
    logic [8:0]  r_dot, n_dot;
    logic [8:0]  r_line, n_line;
    logic        r_odd_frame, n_odd_frame;
    logic [7:0]  r_tile, n_tile;
    logic        r_nt_pending, n_nt_pending;

    // Response stage
    logic        r_out_valid;
    t_rsp        r_rsp, n_rsp;
    logic        r_rd_oam, n_rd_oam;  // response byte comes from the OAM port
    logic [7:0]  r_oam_q;

    logic [7:0]  oam_mem [SPRITE_RAM_DEPTH];
    logic        oam_we;

    logic        req_acc;
    t_req        req;
    logic        is_sel_dma;
    logic [2:0]  sel;

    // Tick decode
    logic        render_line;
    logic        fetch_dot;
    logic [13:0] pat_lo_addr;
    logic [13:0] pat_hi_addr;
    logic [14:0] a_cx;
    logic [14:0] a_fy;

    // ---------------------------------------------------------------------
    // Scroll address steps
    // ---------------------------------------------------------------------
    // Advance coarse X, flip horizontal nametable at the right edge
    function automatic logic [14:0] step_coarse_x(input logic [14:0] a);
        logic [14:0] r;
        if (a[4:0] == 5'd31) begin
            r = {a[14:11], ~a[10], a[9:5], 5'd0};
        end else begin
            r = a + 15'd1;
        end
        return r;
    endfunction

    // Advance fine Y, carrying into the coarse row; row 29 flips the vertical table
    function automatic logic [14:0] step_fine_y(input logic [14:0] a);
        logic [14:0] r;
        logic [4:0]  row;
        logic        flip;
        row  = a[9:5];
        flip = 1'b0;
        if (a[14:12] != 3'd7) begin
            r = {a[14:12] + 3'd1, a[11:0]};
        end else begin
            if (row == ROW_WRAP) begin
                row  = 5'd0;
                flip = 1'b1;
            end else if (row == ROW_LAST) begin
                row = 5'd0;
            end else begin
                row = row + 5'd1;
            end
            r = {3'd0, a[11] ^ flip, a[10], row, a[4:0]};
        end
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Handshake: take a request whenever the response register is free or drains
    // ---------------------------------------------------------------------
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign req_acc     = i_req.valid && i_req.ready;
    assign req         = i_req.data;
    assign is_sel_dma  = (req.reg_addr == DMA_PAGE_ADDR);
    assign sel         = req.reg_addr[2:0];

    assign o_rsp.valid = r_out_valid;

    always_comb begin
        o_rsp.data = r_rsp;
        if (r_rd_oam) begin
            o_rsp.data.read_data = r_oam_q;
        end
    end

    // ---------------------------------------------------------------------
    // Next-state and response logic for one request
    // ---------------------------------------------------------------------
    always_comb begin
        n_cur          = r_cur;
        n_tmp          = r_tmp;
        n_fine_x       = r_fine_x;
        n_second_write = r_second_write;
        n_ctrl         = r_ctrl;
        n_oam_addr     = r_oam_addr;
        n_vblank       = r_vblank;
        n_dot          = r_dot;
        n_line         = r_line;
        n_odd_frame    = r_odd_frame;
        // Latch the tile byte returned for last request's nametable fetch
        n_tile         = r_nt_pending ? req.fetch_data : r_tile;
        n_nt_pending   = 1'b0;
        n_rd_oam       = 1'b0;
        oam_we         = 1'b0;

        n_rsp           = '0;
        n_rsp.mem_kind  = KIND_NONE;
        n_rsp.dot_now   = r_dot;
        n_rsp.line_now  = r_line;

        render_line = (r_line < LINE_VISIBLE) || (r_line == LINE_LAST);
        fetch_dot   = (r_dot <= DOT_FINE_Y) || (r_dot >= DOT_PREFETCH);
        pat_lo_addr = {1'b0, r_ctrl[2], n_tile, 1'b0, r_cur[14:12]};
        pat_hi_addr = {1'b0, r_ctrl[2], n_tile, 1'b1, r_cur[14:12]};

        // Coarse X on tile boundaries, then fine Y at the end of the visible span
        a_cx = r_cur;
        if (r_dot[2:0] == 3'd0 && (r_dot <= DOT_FINE_Y || r_dot == DOT_PREFETCH_A
                || r_dot == DOT_PREFETCH_B)) begin
            a_cx = step_coarse_x(r_cur);
        end
        a_fy = (r_dot == DOT_FINE_Y) ? step_fine_y(a_cx) : a_cx;

        case (req.op)
            OP_TICK: begin
                if (r_dot != 9'd0) begin
                    if (r_dot == 9'd1 && r_line == LINE_VBLANK) begin
                        n_vblank = 1'b1;
                    end
                    if (r_dot == 9'd1 && r_line == LINE_LAST) begin
                        n_vblank = 1'b0;
                    end
                    if (render_line) begin
                        if (fetch_dot) begin
                            case (r_dot[2:0])
                                3'd2: begin
                                    n_rsp.mem_kind = KIND_NT;
                                    n_rsp.mem_addr = NT_BASE | {2'b00, r_cur[11:0]};
                                    n_nt_pending   = 1'b1;
                                end
                                3'd4: begin
                                    n_rsp.mem_kind = KIND_ATTR;
                                    n_rsp.mem_addr = ATTR_BASE
                                        | {2'b00, r_cur[11:10], 10'd0}
                                        | {8'd0, r_cur[9:7], 3'd0}
                                        | {11'd0, r_cur[4:2]};
                                end
                                3'd6: begin
                                    n_rsp.mem_kind = KIND_PAT_LO;
                                    n_rsp.mem_addr = pat_lo_addr;
                                end
                                3'd0: begin
                                    n_rsp.mem_kind = KIND_PAT_HI;
                                    n_rsp.mem_addr = pat_hi_addr;
                                end
                                default: begin
                                end
                            endcase
                        end
                        n_cur = a_fy;
                        if (r_dot == DOT_COPY_H) begin
                            n_cur = (a_fy & ~HORIZ_MASK) | (r_tmp & HORIZ_MASK);
                        end
                        if (r_line == LINE_LAST && r_dot >= DOT_COPY_V_LO
                                && r_dot <= DOT_COPY_V_HI) begin
                            n_cur = (a_fy & ~VERT_MASK) | (r_tmp & VERT_MASK);
                        end
                    end
                end
                // Advance the raster position; odd frames skip the idle dot
                if (r_dot == DOT_LAST) begin
                    n_dot = 9'd0;
                    if (r_line == LINE_LAST) begin
                        n_line      = 9'd0;
                        n_dot       = r_odd_frame ? 9'd1 : 9'd0;
                        n_odd_frame = ~r_odd_frame;
                    end else begin
                        n_line = r_line + 9'd1;
                    end
                end else begin
                    n_dot = r_dot + 9'd1;
                end
            end
            OP_WRITE: begin
                if (!is_sel_dma) begin
                    case (sel)
                        REG_CTRL: begin
                            n_tmp  = {r_tmp[14:12], req.write_data[1:0], r_tmp[9:0]};
                            n_ctrl = {req.write_data[7], req.write_data[5:2]};
                        end
                        REG_OAM_ADDR: begin
                            n_oam_addr = req.write_data;
                        end
                        REG_OAM_DATA: begin
                            oam_we     = 1'b1;
                            n_oam_addr = r_oam_addr + 8'd1;
                        end
                        REG_SCROLL: begin
                            if (!r_second_write) begin
                                n_fine_x = req.write_data[2:0];
                                n_tmp    = {r_tmp[14:5], req.write_data[7:3]};
                            end else begin
                                n_tmp = {req.write_data[2:0], r_tmp[11:10],
                                         req.write_data[7:3], r_tmp[4:0]};
                            end
                            n_second_write = ~r_second_write;
                        end
                        REG_ADDR: begin
                            if (!r_second_write) begin
                                n_tmp = {req.write_data[6:0], r_tmp[7:0]};
                            end else begin
                                n_tmp = {r_tmp[14:8], req.write_data};
                                n_cur = {r_tmp[14:8], req.write_data};
                            end
                            n_second_write = ~r_second_write;
                        end
                        REG_DATA: begin
                            n_rsp.mem_kind  = KIND_CPU_WR;
                            n_rsp.mem_addr  = r_cur[13:0];
                            n_rsp.mem_wdata = req.write_data;
                            n_cur = r_cur + (r_ctrl[0] ? 15'd32 : 15'd1);
                        end
                        default: begin
                            // mask and status writes have no visible effect
                        end
                    endcase
                end
            end
            OP_READ: begin
                if (!is_sel_dma) begin
                    case (sel)
                        REG_STATUS: begin
                            n_rsp.read_data = {r_vblank, 7'd0};
                            n_vblank        = 1'b0;
                            n_second_write  = 1'b0;
                        end
                        REG_OAM_ADDR: begin
                            n_rsp.read_data = r_oam_addr;
                        end
                        REG_OAM_DATA: begin
                            n_rd_oam = 1'b1;
                        end
                        REG_DATA: begin
                            n_rsp.mem_kind = KIND_CPU_RD;
                            n_rsp.mem_addr = r_cur[13:0];
                            n_cur = r_cur + (r_ctrl[0] ? 15'd32 : 15'd1);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                // undefined op: report position, change nothing else but the pending tile latch
            end
        endcase

        n_rsp.vblank_flag = n_vblank;
        n_rsp.nmi_line    = n_vblank && n_ctrl[4];
        n_rsp.fine_x_out  = n_fine_x;
    end

    // ---------------------------------------------------------------------
    // State and response registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur          <= '0;
            r_tmp          <= '0;
            r_fine_x       <= '0;
            r_second_write <= 1'b0;
            r_ctrl         <= '0;
            r_oam_addr     <= '0;
            r_vblank       <= 1'b0;
            r_dot          <= '0;
            r_line         <= '0;
            r_odd_frame    <= 1'b0;
            r_tile         <= '0;
            r_nt_pending   <= 1'b0;
            r_out_valid    <= 1'b0;
            r_rd_oam       <= 1'b0;
        end else begin
            if (req_acc) begin
                r_cur          <= n_cur;
                r_tmp          <= n_tmp;
                r_fine_x       <= n_fine_x;
                r_second_write <= n_second_write;
                r_ctrl         <= n_ctrl;
                r_oam_addr     <= n_oam_addr;
                r_vblank       <= n_vblank;
                r_dot          <= n_dot;
                r_line         <= n_line;
                r_odd_frame    <= n_odd_frame;
                r_tile         <= n_tile;
                r_nt_pending   <= n_nt_pending;
                r_rd_oam       <= n_rd_oam;
                r_out_valid    <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Response payload: load with each accepted request, hold while stalled
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_rsp <= n_rsp;
        end
    end

    // OAM: one write port, one registered read port, both at the OAM address
    always_ff @(posedge i_clk) begin
        if (req_acc && oam_we) begin
            oam_mem[r_oam_addr[OAM_AW-1:0]] <= req.write_data;
        end
        if (req_acc) begin
            r_oam_q <= oam_mem[r_oam_addr[OAM_AW-1:0]];
        end
    end

`ifndef SYNTHESIS
    // Raster counters stay inside the frame
    a_raster_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dot <= DOT_LAST) && (r_line <= LINE_LAST))
        else $error("raster counter out of range");

    // A tick at the vblank line start raises the flag
    a_vblank_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_acc && req.op == OP_TICK && r_dot == 9'd1 && r_line == LINE_VBLANK)
        |=> r_vblank)
        else $error("vblank not set at start of vblank line");

    // A pending tile latch only follows an accepted nametable fetch
    a_nt_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_nt_pending) |-> $past(req_acc) && r_rsp.mem_kind == KIND_NT)
        else $error("tile latch armed without nametable fetch");

    // The reserved request kind is never issued
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_rsp.mem_kind != KIND_RESERVED)
        else $error("reserved memory request kind issued");

    // An empty response register never holds off requests
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_req.ready)
        else $error("request stalled with empty response register");
`endif

endmodule
